/* design/sacp_pkg.sv */
// ----------------------------------------------------------------------------
// sacp_pkg: shared types and codes for the cache tag and replacement block
// Holds policy codes, register indexes, the per-way entry layout, the
// controller states and the LFSR step.
// ----------------------------------------------------------------------------
`default_nettype none
package sacp_pkg;

  localparam int DefWays    = 4;
  localparam int DefMaxSets = 256;

  // Replacement policy codes
  localparam logic [2:0] POL_LRU  = 3'd0;
  localparam logic [2:0] POL_PLRU = 3'd1;
  localparam logic [2:0] POL_FIFO = 3'd2;
  localparam logic [2:0] POL_RAND = 3'd3;
  localparam logic [2:0] POL_RRIP = 3'd4;
  localparam logic [2:0] POL_MRU  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_POLICY   = 2'd0;
  localparam logic [1:0] CFG_LINE_LOG = 2'd1;
  localparam logic [1:0] CFG_SET_LOG  = 2'd2;
  localparam logic [1:0] CFG_SEED     = 2'd3;

  localparam logic [1:0]  RRIP_MAX    = 2'd3;
  localparam logic [1:0]  RRIP_INSERT = 2'd2;
  localparam logic [15:0] LFSR_MASK   = 16'hB400;
  localparam int          PLRU_W      = 7;

  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] stamp;
    logic [1:0]  rrip;
  } way_t;

  typedef enum logic {ST_IDLE, ST_LOOK} state_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] n;
    n = v >> 1;
    if (v[0]) n = n ^ LFSR_MASK;
    return n;
  endfunction

endpackage
`default_nettype wire

/* design/sacp_ram.sv */
// ----------------------------------------------------------------------------
// sacp_ram: generic single-write, single-read synchronous RAM
// One write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module sacp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/set_assoc_cache_tag_policy.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_policy: tag lookup with selectable replacement policy
// Looks up a byte address across WAYS ways of one set, fills on a miss.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive address with start high; the beat is taken at an edge
//   where start is high and busy is low. busy is high for the lookup cycle.
//   Result beat: done is high for exactly one cycle with hit, way, set_sel,
//   hit_total and miss_total. The receiver cannot stall; it must take it.
//   Steps: the accept edge reads the set row from the tag RAM and moves the
//   block to the lookup state; the lookup state compares all ways, picks
//   the victim and writes the row back, and done is registered from the
//   lookup state. The next access is taken only after the write-back, so a
//   read never sees stale data for the same set.
//   Config: cfg_we writes cfg_data into register cfg_index at any edge
//   (0 policy, 1 line size log2, 2 set count log2, 3 random seed).
//   Write config only while idle.
//   Reset: rst clears counters, access clock and a per-set row-valid flop
//   array; a row not yet written reads as all zero, so no clearing pass runs.
//   The LFSR loads 1; a seed write of zero also loads 1.
// ----------------------------------------------------------------------------
`default_nettype none
module set_assoc_cache_tag_policy
  import sacp_pkg::*;
#(
  parameter int WAYS     = DefWays,
  parameter int MAX_SETS = DefMaxSets
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] address,
  output logic             done,
  output logic             hit,
  output logic [2:0]       way,
  output logic [7:0]       set_sel,
  output logic [31:0]      hit_total,
  output logic [31:0]      miss_total,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int SET_W = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int TL    = WAYS >= 8 ? 3 : (WAYS >= 4 ? 2 : (WAYS >= 2 ? 1 : 0));
  localparam int ROW_W = PLRU_W + WAYS * $bits(way_t);

  // Configuration
  logic [2:0]  policy;
  logic [3:0]  line_log;
  logic [3:0]  set_log;
  logic [15:0] lfsr;

  state_t state, state_next;
  logic   accept;

  // Per-access registers
  logic [31:0]      tag_q;
  logic [SET_W-1:0] set_q;
  logic [7:0]       set8_q;
  logic [10:0]      rnd_part;
  logic [31:0]      access_clock;
  logic [31:0]      hit_cnt, miss_cnt;
  logic [MAX_SETS-1:0] row_vld;

  // Address split and set reduction
  logic [31:0]      line, tag_d;
  logic [7:0]       set_raw;
  logic [7:0]       set_red;
  logic [3:0]       klim;
  logic [10:0]      rnd_d;

  always_comb begin
    logic [16:0] rr;
    logic [19:0] lr;
    line    = address >> line_log;
    tag_d   = line >> set_log;
    klim    = (set_log > 4'd8) ? 4'd8 : set_log;
    set_raw = 8'((9'(line[7:0]) & ((9'd1 << klim) - 9'd1)));
    rr = {9'b0, set_raw};
    for (int i = 7; i >= 0; i--) begin
      if (rr >= (17'(MAX_SETS) << i)) rr = rr - (17'(MAX_SETS) << i);
    end
    set_red = rr[7:0];
    // first half of the LFSR residue, candidate value is the next LFSR state
    lr = {4'b0, lfsr_step(lfsr)};
    for (int i = 15; i >= 8; i--) begin
      if (lr >= (20'(WAYS) << i)) lr = lr - (20'(WAYS) << i);
    end
    rnd_d = lr[10:0];
  end

  // Tag RAM: one row per set
  logic [ROW_W-1:0] rd_row, wr_row;
  logic             ram_we;

  sacp_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (set_q),
    .wdata (wr_row),
    .re    (accept),
    .raddr (set_red[SET_W-1:0]),
    .rdata (rd_row)
  );

  // State machine
  always_comb begin
    case (state)
      ST_IDLE: state_next = (start) ? ST_LOOK : ST_IDLE;
      ST_LOOK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: busy = 1'b0;
      ST_LOOK: busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  assign accept = start && !busy;
  assign ram_we = (state == ST_LOOK);

  // Lookup, victim choice and row update
  way_t [WAYS-1:0]  cur_ways, new_ways;
  logic [PLRU_W-1:0] cur_plru, new_plru;
  logic             hit_c;
  logic [WAY_W-1:0] way_c;
  logic             rnd_step;
  logic [31:0]      clk_next;

  assign clk_next = access_clock + 32'd1;

  always_comb begin
    logic             inv_found;
    logic [WAY_W-1:0] inv_way, old_way, plru_way, rrip_way, rnd_way, vic;
    logic [31:0]      min_st;
    logic [1:0]       mx, d;
    logic [2:0]       node;
    logic [2:0]       r3;
    logic [10:0]      rr;
    way_t [WAYS-1:0]  aged;

    if (row_vld[set_q]) begin
      cur_ways = rd_row[WAYS*$bits(way_t)-1:0];
      cur_plru = rd_row[ROW_W-1 -: PLRU_W];
    end else begin
      cur_ways = '0;
      cur_plru = '0;
    end

    hit_c = 1'b0;
    way_c = '0;
    vic = '0;
    inv_found = 1'b0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (cur_ways[w].valid && cur_ways[w].tag == tag_q) begin
        hit_c = 1'b1;
        way_c = WAY_W'(w);
      end
      if (!cur_ways[w].valid) begin
        inv_found = 1'b1;
        inv_way = WAY_W'(w);
      end
    end

    // oldest stamp, lowest way on ties
    old_way = '0;
    min_st = cur_ways[0].stamp;
    for (int w = 1; w < WAYS; w++) begin
      if (cur_ways[w].stamp < min_st) begin
        min_st = cur_ways[w].stamp;
        old_way = WAY_W'(w);
      end
    end

    // tree walk, MSB first
    plru_way = '0;
    node = '0;
    for (int lv = 0; lv < TL; lv++) begin
      if (cur_plru[node]) begin
        plru_way = plru_way | WAY_W'(1 << (TL - lv - 1));
        node = 3'(node * 2 + 2);
      end else begin
        node = 3'(node * 2 + 1);
      end
    end

    // finish LFSR residue
    rr = rnd_part;
    for (int i = 7; i >= 0; i--) begin
      if (rr >= (11'(WAYS) << i)) rr = rr - (11'(WAYS) << i);
    end
    rnd_way = WAY_W'(rr);

    // RRIP: age to max, first way at max is the victim
    mx = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (cur_ways[w].rrip > mx) mx = cur_ways[w].rrip;
    end
    rrip_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (cur_ways[w].rrip == mx) rrip_way = WAY_W'(w);
    end
    d = RRIP_MAX - mx;
    aged = cur_ways;
    for (int w = 0; w < WAYS; w++) begin
      r3 = 3'(cur_ways[w].rrip) + 3'(d);
      if (WAY_W'(w) != rrip_way && r3 < 3'(RRIP_MAX)) r3 = r3 + 3'd1;
      aged[w].rrip = r3[1:0];
    end

    new_ways = cur_ways;
    new_plru = cur_plru;
    rnd_step = 1'b0;

    if (!hit_c) begin
      if (inv_found) begin
        vic = inv_way;
      end else begin
        case (policy)
          POL_LRU, POL_FIFO: vic = old_way;
          POL_PLRU:          vic = plru_way;
          POL_RAND: begin
            vic = rnd_way;
            rnd_step = 1'b1;
          end
          POL_RRIP, POL_MRU: begin
            vic = rrip_way;
            new_ways = aged;
          end
          default:           vic = '0;
        endcase
      end
      way_c = vic;
    end

    // touch the accessed way
    if (!hit_c) begin
      new_ways[way_c].valid = 1'b1;
      new_ways[way_c].tag   = tag_q;
    end
    case (policy)
      POL_LRU:  new_ways[way_c].stamp = clk_next;
      POL_FIFO: if (!hit_c) new_ways[way_c].stamp = clk_next;
      POL_RRIP: new_ways[way_c].rrip = hit_c ? 2'd0 : RRIP_INSERT;
      POL_MRU: begin
        if (!hit_c) new_ways[way_c].rrip = RRIP_MAX;
        else if (new_ways[way_c].rrip != 2'd0)
          new_ways[way_c].rrip = new_ways[way_c].rrip - 2'd1;
      end
      default: ;
    endcase
    if (policy == POL_PLRU) begin
      node = '0;
      for (int lv = 0; lv < TL; lv++) begin
        if (way_c[TL - lv - 1] == 1'b0) begin
          new_plru[node] = 1'b1;
          node = 3'(node * 2 + 1);
        end else begin
          new_plru[node] = 1'b0;
          node = 3'(node * 2 + 2);
        end
      end
    end
  end

  assign wr_row = {new_plru, new_ways};

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      policy       <= POL_LRU;
      line_log     <= 4'd6;
      set_log      <= 4'd8;
      lfsr         <= 16'd1;
      access_clock <= '0;
      hit_cnt      <= '0;
      miss_cnt     <= '0;
      row_vld      <= '0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_LOOK);
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLICY:   policy   <= cfg_data[2:0];
          CFG_LINE_LOG: line_log <= cfg_data[3:0];
          CFG_SET_LOG:  set_log  <= cfg_data[3:0];
          CFG_SEED:     lfsr     <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
          default: ;
        endcase
      end
      if (state == ST_LOOK) begin
        access_clock <= clk_next;
        row_vld[set_q] <= 1'b1;
        if (hit_c) hit_cnt <= hit_cnt + 32'd1;
        else       miss_cnt <= miss_cnt + 32'd1;
        if (rnd_step) lfsr <= lfsr_step(lfsr);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      tag_q    <= tag_d;
      set_q    <= set_red[SET_W-1:0];
      set8_q   <= set_red;
      rnd_part <= rnd_d;
    end
    if (state == ST_LOOK) begin
      hit        <= hit_c;
      way        <= 3'(way_c);
      set_sel    <= set8_q;
      hit_total  <= hit_c ? hit_cnt + 32'd1 : hit_cnt;
      miss_total <= hit_c ? miss_cnt : miss_cnt + 32'd1;
    end
  end
endmodule
`default_nettype wire

/* design/sacp_checker.sv */
// ----------------------------------------------------------------------------
// sacp_checker: port-level checks for the cache tag block
// Watches the start/busy/done timing seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module sacp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done) else $error("result beat missing");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result beat while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result beat repeated");
endmodule

bind set_assoc_cache_tag_policy sacp_checker u_sacp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
`default_nettype wire
